// File: rtl/sbh_pkg.sv
// Shared types and constants for the sponge byte hash block.
// Used by sbh_perm, sbh_ctrl and sponge_byte_hash_top; no dependencies.
package sbh_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_AW    = 8;
    localparam int PERM_DEPTH = 256;

    // Base of the upper half where nibbles are swapped in
    localparam logic [PERM_AW-1:0] HALF_BASE  = 8'd128;
    localparam logic [3:0]         NIBBLE_MSK = 4'hf;

    // Request codes
    localparam logic [1:0] REQ_INIT   = 2'd0;
    localparam logic [1:0] REQ_ABSORB = 2'd1;
    localparam logic [1:0] REQ_DRIP   = 2'd2;

    // Access request from the sequencer to the permutation store
    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [PERM_AW-1:0] rd_addr;
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [BYTE_W-1:0]  wr_data;
    } perm_req_t;

    // Finished output byte offered by the sequencer
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } sbh_res_t;

endpackage

// File: rtl/sbh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module sbh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sbh_perm.sv
// Permutation store: the byte RAM plus one valid bit per entry.
// An entry that is not valid reads as its own address (identity).
// Depends on sbh_pkg and sbh_ram.
module sbh_perm
    import sbh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  perm_req_t         req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [PERM_DEPTH-1:0] vld_reg;
    logic [PERM_DEPTH-1:0] vld_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [PERM_AW-1:0]    addr_reg;
    logic [PERM_AW-1:0]    addr_next;
    logic [BYTE_W-1:0]     ram_q;

    sbh_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    // Drop all valid bits on clear, mark written entries
    always_comb
    begin
        vld_next = vld_reg;
        if (req.clear)
        begin
            vld_next = '0;
        end
        else if (req.wr_en)
        begin
            vld_next[req.wr_addr] = 1'b1;
        end
    end

    // Capture the valid bit and address alongside the RAM read
    always_comb
    begin
        hit_next  = hit_reg;
        addr_next = addr_reg;
        if (req.rd_en)
        begin
            hit_next  = vld_reg[req.rd_addr];
            addr_next = req.rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            hit_reg  <= 1'b0;
            addr_reg <= '0;
        end
        else
        begin
            vld_reg  <= vld_next;
            hit_reg  <= hit_next;
            addr_reg <= addr_next;
        end
    end

    assign rd_data = hit_reg ? ram_q : addr_reg;

endmodule

// File: rtl/sbh_ctrl.sv
// Sequencer for the sponge byte hash: index registers and the state machine
// that reads, modifies and writes back the permutation store.
// Depends on sbh_pkg.
module sbh_ctrl
    import sbh_pkg::*;
#(
    parameter int WHIP_ROUNDS = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [BYTE_W-1:0] rd_data,
    input  logic              res_take,
    output logic              idle,
    output perm_req_t         preq,
    output sbh_res_t          res
);

    localparam int RW = (WHIP_ROUNDS > 1) ? $clog2(WHIP_ROUNDS) : 1;
    localparam logic [RW-1:0] ROUND_LAST = RW'(WHIP_ROUNDS - 1);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_NB_RA  = 13'b0000000000010,
        ST_NB_RB  = 13'b0000000000100,
        ST_NB_WA  = 13'b0000000001000,
        ST_NB_WB  = 13'b0000000010000,
        ST_UP_RI  = 13'b0000000100000,
        ST_UP_RY  = 13'b0000001000000,
        ST_UP_RJ  = 13'b0000010000000,
        ST_UP_WI  = 13'b0000100000000,
        ST_UP_WJ  = 13'b0001000000000,
        ST_OUT_R1 = 13'b0010000000000,
        ST_OUT_R2 = 13'b0100000000000,
        ST_OUT_R3 = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic              drip_reg, drip_next;
    logic              nib_hi_reg, nib_hi_next;
    logic              shuf_reg, shuf_next;
    logic              send_reg, send_next;
    logic [RW-1:0]     cnt_reg, cnt_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BYTE_W-1:0] tmp_reg, tmp_next;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] k_reg, k_next;
    logic [BYTE_W-1:0] w_reg, w_next;
    logic [BYTE_W-1:0] last_reg, last_next;

    logic [3:0]         nib;
    logic [PERM_AW-1:0] nib_addr;

    // Current nibble and its swap partner in the upper half
    assign nib      = (nib_hi_reg ? byte_reg[7:4] : byte_reg[3:0]) & NIBBLE_MSK;
    assign nib_addr = HALF_BASE | {4'b0000, nib};

    always_comb
    begin
        state_next  = state_reg;
        drip_next   = drip_reg;
        nib_hi_next = nib_hi_reg;
        shuf_next   = shuf_reg;
        send_next   = send_reg;
        cnt_next    = cnt_reg;
        byte_next   = byte_reg;
        tmp_next    = tmp_reg;
        pos_next    = pos_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        w_next      = w_reg;
        last_next   = last_reg;
        preq        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Output byte waits here until the output register frees up
                if (send_reg)
                begin
                    if (res_take)
                    begin
                        send_next = 1'b0;
                    end
                end
                else if (start)
                begin
                    byte_next = data_byte;
                    if (req_type == REQ_INIT)
                    begin
                        preq.clear = 1'b1;
                        pos_next   = '0;
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        w_next     = 8'd1;
                        last_next  = '0;
                    end
                    else if (req_type == REQ_ABSORB)
                    begin
                        drip_next   = 1'b0;
                        nib_hi_next = 1'b0;
                        state_next  = ST_NB_RA;
                    end
                    else if (req_type == REQ_DRIP)
                    begin
                        drip_next  = 1'b1;
                        shuf_next  = (pos_reg != '0);
                        cnt_next   = '0;
                        state_next = ST_UP_RI;
                    end
                end
            end

            // Nibble swap: shuffle first when the lower half is full
            ST_NB_RA:
            begin
                if (pos_reg == HALF_BASE)
                begin
                    shuf_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_UP_RI;
                end
                else
                begin
                    preq.rd_en   = 1'b1;
                    preq.rd_addr = pos_reg;
                    state_next   = ST_NB_RB;
                end
            end

            ST_NB_RB:
            begin
                tmp_next     = rd_data;
                preq.rd_en   = 1'b1;
                preq.rd_addr = nib_addr;
                state_next   = ST_NB_WA;
            end

            ST_NB_WA:
            begin
                preq.wr_en   = 1'b1;
                preq.wr_addr = pos_reg;
                preq.wr_data = rd_data;
                state_next   = ST_NB_WB;
            end

            ST_NB_WB:
            begin
                preq.wr_en   = 1'b1;
                preq.wr_addr = nib_addr;
                preq.wr_data = tmp_reg;
                pos_next     = pos_reg + 8'd1;
                if (nib_hi_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    nib_hi_next = 1'b1;
                    state_next  = ST_NB_RA;
                end
            end

            // Update: advance i and fetch perm[i]
            ST_UP_RI:
            begin
                i_next       = i_reg + w_reg;
                preq.rd_en   = 1'b1;
                preq.rd_addr = i_reg + w_reg;
                state_next   = ST_UP_RY;
            end

            ST_UP_RY:
            begin
                tmp_next     = rd_data;
                preq.rd_en   = 1'b1;
                preq.rd_addr = j_reg + rd_data;
                state_next   = ST_UP_RJ;
            end

            ST_UP_RJ:
            begin
                j_next       = k_reg + rd_data;
                preq.rd_en   = 1'b1;
                preq.rd_addr = k_reg + rd_data;
                state_next   = ST_UP_WI;
            end

            ST_UP_WI:
            begin
                k_next       = i_reg + k_reg + rd_data;
                preq.wr_en   = 1'b1;
                preq.wr_addr = i_reg;
                preq.wr_data = rd_data;
                state_next   = ST_UP_WJ;
            end

            ST_UP_WJ:
            begin
                preq.wr_en   = 1'b1;
                preq.wr_addr = j_reg;
                preq.wr_data = tmp_reg;
                if (shuf_reg)
                begin
                    if (cnt_reg == ROUND_LAST)
                    begin
                        shuf_next  = 1'b0;
                        w_next     = w_reg + 8'd2;
                        pos_next   = '0;
                        state_next = drip_reg ? ST_UP_RI : ST_NB_RA;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + RW'(1);
                        state_next = ST_UP_RI;
                    end
                end
                else
                begin
                    state_next = ST_OUT_R1;
                end
            end

            // Output chain of three dependent reads
            ST_OUT_R1:
            begin
                preq.rd_en   = 1'b1;
                preq.rd_addr = last_reg + k_reg;
                state_next   = ST_OUT_R2;
            end

            ST_OUT_R2:
            begin
                preq.rd_en   = 1'b1;
                preq.rd_addr = i_reg + rd_data;
                state_next   = ST_OUT_R3;
            end

            ST_OUT_R3:
            begin
                preq.rd_en   = 1'b1;
                preq.rd_addr = j_reg + rd_data;
                send_next    = 1'b1;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Offer the squeezed byte to the output register as it returns from the store
    always_comb
    begin
        res.valid = (state_reg == ST_IDLE) && send_reg;
        res.data  = rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            drip_reg   <= 1'b0;
            nib_hi_reg <= 1'b0;
            shuf_reg   <= 1'b0;
            send_reg   <= 1'b0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            w_reg      <= 8'd1;
            last_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            drip_reg   <= drip_next;
            nib_hi_reg <= nib_hi_next;
            shuf_reg   <= shuf_next;
            send_reg   <= send_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            w_reg      <= w_next;
            last_reg   <= (res.valid && res_take) ? rd_data : last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        tmp_reg  <= tmp_next;
    end

    assign idle = (state_reg == ST_IDLE) && !send_reg;

endmodule

// File: rtl/sponge_byte_hash_top.sv
// Sponge byte hash: a Spritz-style hash over a 256-entry byte permutation.
// Channels: input beat (req_type, data_byte) on in_valid / in_stall, output
// beat hash_byte on out_valid / out_stall. A beat moves at a rising edge
// where valid is high and stall is low.
// Requests: init puts the permutation back to identity by dropping the
// per-entry valid bits; absorb folds in one byte (two nibble swaps); drip
// squeezes one hash byte. Other codes are dropped.
// Each request runs as a chain of single accesses to the store, which has one
// read and one write port: absorb does two nibble swaps; drip does one update
// (after any shuffle) and three output reads; a shuffle does WHIP_ROUNDS
// updates. A shuffle runs once every 64 absorbed bytes and before a drip that
// follows absorbing.
// One request is worked at a time; in_stall is high while it is in progress.
// The output register holds a finished byte while out_stall is high, and
// new requests are taken meanwhile; a drip that finishes while the register
// is still full waits until it is taken.
// Reset (rst_n low, asynchronous) gives the init state with no beat pending.
// Depends on sbh_pkg, sbh_ram, sbh_perm and sbh_ctrl.
module sponge_byte_hash_top
    import sbh_pkg::*;
#(
    parameter int WHIP_ROUNDS = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] hash_byte
);

    perm_req_t         preq;
    sbh_res_t          res;
    logic [BYTE_W-1:0] rd_data;
    logic              idle;
    logic              start;
    logic              res_take;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] hash_byte_reg;

    sbh_perm u_perm (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (preq),
        .rd_data (rd_data)
    );

    sbh_ctrl #(
        .WHIP_ROUNDS (WHIP_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .data_byte (data_byte),
        .rd_data   (rd_data),
        .res_take  (res_take),
        .idle      (idle),
        .preq      (preq),
        .res       (res)
    );

    // Accept a request only while the sequencer is free
    assign in_stall = !idle;
    assign start    = in_valid && idle;

    // Output register: load when empty or being drained
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_take)
        begin
            hash_byte_reg <= res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign hash_byte = hash_byte_reg;

endmodule

// File: test/tb.sv
// Self-checking testbench for sponge_byte_hash_top: a directed table and then
// random hash sessions, with every drip checked against a byte-exact predictor.
// Depends on sbh_pkg and the sponge_byte_hash_top RTL.
module tb;
    import sbh_pkg::*;

    localparam int WHIP_ROUNDS  = 512;
    localparam int HALF_PERIOD  = 5;
    localparam int RANDOM_ITEMS = 550;
    localparam int TAIL_CYCLES  = 64;
    // Worst case: every beat pays a full shuffle (5 accesses per update) plus
    // long stalls on both sides, taken several times over
    localparam int LIMIT_CYCLES = 10_000_000;

    // Request code the block drops
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [1:0]        req_type  = REQ_INIT;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] hash_byte;

    sponge_byte_hash_top #(
        .WHIP_ROUNDS(WHIP_ROUNDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hash_byte(hash_byte)
    );

    always #HALF_PERIOD clk = ~clk;

    // Hash state as predicted from the accepted beats
    logic [BYTE_W-1:0] perm_st [PERM_DEPTH];
    logic [BYTE_W-1:0] mix_pos;
    logic [BYTE_W-1:0] cur_i;
    logic [BYTE_W-1:0] cur_j;
    logic [BYTE_W-1:0] cur_k;
    logic [BYTE_W-1:0] stride;
    logic [BYTE_W-1:0] prev_out;

    logic [BYTE_W-1:0] expected_hash_q [$];
    logic [BYTE_W-1:0] due_hash;
    int                mismatches  = 0;
    int                beats_taken = 0;
    int                cycle_cnt   = 0;
    logic              steady      = 1'b0;

    function automatic void reset_hash_state();
        for (int v = 0; v < PERM_DEPTH; v++)
            perm_st[v] = BYTE_W'(v);
        mix_pos  = '0;
        cur_i    = '0;
        cur_j    = '0;
        cur_k    = '0;
        stride   = 8'd1;
        prev_out = '0;
    endfunction

    function automatic void swap_perm(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] q);
        logic [BYTE_W-1:0] t;
        t          = perm_st[p];
        perm_st[p] = perm_st[q];
        perm_st[q] = t;
    endfunction

    // One update of the i, j, k walk with its swap
    function automatic void stir();
        logic [BYTE_W-1:0] y;
        cur_i = cur_i + stride;
        y     = cur_j + perm_st[cur_i];
        cur_j = cur_k + perm_st[y];
        cur_k = cur_i + cur_k + perm_st[cur_j];
        swap_perm(cur_i, cur_j);
    endfunction

    function automatic logic [BYTE_W-1:0] squeeze();
        logic [BYTE_W-1:0] y1;
        logic [BYTE_W-1:0] x1;
        logic [BYTE_W-1:0] y2;
        y1       = prev_out + cur_k;
        x1       = cur_i + perm_st[y1];
        y2       = cur_j + perm_st[x1];
        prev_out = perm_st[y2];
        return prev_out;
    endfunction

    // Reduced shuffle: no crush, no absorb-stop
    function automatic void whip();
        for (int r = 0; r < WHIP_ROUNDS; r++)
            stir();
        stride  = stride + 8'd2;
        mix_pos = '0;
    endfunction

    function automatic void fold_nibble(input logic [3:0] nib);
        if (mix_pos == HALF_BASE)
            whip();
        swap_perm(mix_pos, HALF_BASE + {4'd0, nib & NIBBLE_MSK});
        mix_pos = mix_pos + 8'd1;
    endfunction

    // Advance the predicted state by one request; flag a hash byte if one is due
    function automatic void hash_step(input logic [1:0] rq, input logic [BYTE_W-1:0] db,
                                      output logic has_out, output logic [BYTE_W-1:0] out_b);
        has_out = 1'b0;
        out_b   = '0;
        case (rq)
            REQ_INIT:
                reset_hash_state();
            REQ_ABSORB:
            begin
                fold_nibble(db[3:0]);
                fold_nibble(db[7:4]);
            end
            REQ_DRIP:
            begin
                if (mix_pos != 0)
                    whip();
                stir();
                out_b   = squeeze();
                has_out = 1'b1;
            end
            default:
                ;
        endcase
    endfunction

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 28);
    endfunction

    // Offer one beat, idling at random first; predict once it is taken
    task automatic push_beat(input logic [1:0] rq, input logic [BYTE_W-1:0] db,
                             input logic known, input logic [BYTE_W-1:0] known_hash);
        logic              has_out;
        logic [BYTE_W-1:0] out_b;
        while (take_gap())
        begin
            in_valid  <= 1'b0;
            req_type  <= 2'($urandom_range(3));
            data_byte <= 8'($urandom_range(255));
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        data_byte <= db;
        do
            @(posedge clk);
        while (in_stall);
        hash_step(rq, db, has_out, out_b);
        if (has_out)
            expected_hash_q.push_back(known ? known_hash : out_b);
        if (rq != REQ_UNUSED)
            beats_taken++;
    endtask

    // Hold the input side idle until every hash byte due has been taken
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_hash_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Check each output beat against the oldest due byte; stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hash_q.size() == 0)
            begin
                $error("hash_byte: expected no beat, actual %02h", hash_byte);
                mismatches++;
            end
            else
            begin
                due_hash = expected_hash_q.pop_front();
                if (hash_byte !== due_hash)
                begin
                    $error("hash_byte: expected %02h, actual %02h", due_hash, hash_byte);
                    mismatches++;
                end
            end
        end
        out_stall <= take_gap();
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    typedef struct packed {
        logic [1:0]        req;
        logic [BYTE_W-1:0] data;
        logic [7:0]        reps;
        logic              known;
        logic [BYTE_W-1:0] hash;
    } stim_row_t;

    // Rows with a repeat count absorb data, data + 1, ... in turn
    localparam int N_ROWS = 25;
    stim_row_t stim_table [N_ROWS] = '{
        '{REQ_DRIP,   8'h00, 8'd1,  1'b1, 8'd4},   // first drip from the init state
        '{REQ_DRIP,   8'h00, 8'd1,  1'b1, 8'd20},
        '{REQ_INIT,   8'hff, 8'd1,  1'b0, 8'h00},
        '{REQ_DRIP,   8'h00, 8'd1,  1'b1, 8'd4},
        '{REQ_UNUSED, 8'hff, 8'd1,  1'b0, 8'h00},  // dropped: next drip carries on
        '{REQ_DRIP,   8'h00, 8'd1,  1'b1, 8'd20},
        '{REQ_INIT,   8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'hff, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'h0f, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'hf0, 8'd1,  1'b0, 8'h00},
        '{REQ_DRIP,   8'h00, 8'd1,  1'b0, 8'h00},  // shuffle first
        '{REQ_DRIP,   8'hff, 8'd1,  1'b0, 8'h00},  // no shuffle
        '{REQ_UNUSED, 8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'ha5, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'h5a, 8'd1,  1'b0, 8'h00},
        '{REQ_DRIP,   8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_INIT,   8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'h00, 8'd64, 1'b0, 8'h00},  // fill the lower half
        '{REQ_ABSORB, 8'hff, 8'd1,  1'b0, 8'h00},  // shuffle before the swap
        '{REQ_DRIP,   8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_DRIP,   8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_INIT,   8'h00, 8'd1,  1'b0, 8'h00},
        '{REQ_ABSORB, 8'hc3, 8'd64, 1'b0, 8'h00},
        '{REQ_DRIP,   8'h00, 8'd1,  1'b0, 8'h00}   // drip at the half mark
    };

    initial
    begin
        int msg;
        int n;
        int pick;
        reset_hash_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (stim_table[r])
            for (int k = 0; k < stim_table[r].reps; k++)
                push_beat(stim_table[r].req, stim_table[r].data + 8'(k),
                          stim_table[r].known, stim_table[r].hash);
        settle();

        // Random sessions: mostly init, absorb a message, drip a few bytes
        beats_taken = 0;
        msg = 0;
        while (beats_taken < RANDOM_ITEMS)
        begin
            steady <= (msg >= 6 && msg < 12);
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(3) != 0)
                    push_beat(REQ_INIT, 8'($urandom_range(255)), 1'b0, '0);
                pick = $urandom_range(99);
                if (pick < 70)
                    n = $urandom_range(20);
                else if (pick < 90)
                    n = $urandom_range(63, 21);
                else
                    n = $urandom_range(140, 64);
                repeat (n)
                    push_beat(REQ_ABSORB, 8'($urandom_range(255)), 1'b0, '0);
                repeat ($urandom_range(6, 1))
                    push_beat(REQ_DRIP, 8'($urandom_range(255)), 1'b0, '0);
            end
            else
            begin
                // Noise: any code, any data, in any order
                repeat ($urandom_range(8, 1))
                    push_beat(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
            end
            if (msg % 5 == 4)
                settle();
            msg++;
        end
        steady <= 1'b0;

        // Drain, then watch for stray beats
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_hash_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/sbh_pkg.sv
rtl/sbh_ram.sv
rtl/sbh_perm.sv
rtl/sbh_ctrl.sv
rtl/sponge_byte_hash_top.sv
test/tb.sv
